@@ design/chm_pkg.sv @@
// Shared types and constants for the chained hash map.
package chm_pkg;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // Width of the bucket_count register
    localparam int CFG_BITS = 9;

    // Classification handed from the front part to the back part
    typedef struct packed {
        logic [1:0] cmd;
        logic       is_zero;   // key was zero: answer at once
        logic       is_bad;    // unused command code: answer at once
    } t_cls;

endpackage

@@ design/chm_ram.sv @@
// Generic single-port RAM with registered read.
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/chm_front.sv @@
// Front part: accepts command beats, computes the bucket, queues the work.
module chm_front #(
    parameter int MAX_BUCKETS = 256,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    parameter int BKT_W       = 8,
    parameter int REM_W       = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [KEY_BITS-1:0]      i_key,
    input  logic [VALUE_BITS-1:0]    i_value,
    input  logic [REM_W-1:0]         i_bucket_count,
    // queue toward the back part
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output chm_pkg::t_cls            o_q_cls,
    output logic [KEY_BITS-1:0]      o_q_key,
    output logic [VALUE_BITS-1:0]    o_q_value,
    output logic [BKT_W-1:0]         o_q_bucket
);

    localparam int SH_W  = KEY_BITS - 2;
    localparam int CNT_W = $clog2(SH_W + 1);

    // Modulo unit: restoring remainder, one key bit per cycle
    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SH_W-1:0]       r_sh, n_sh;
    logic [REM_W:0]        r_rem, n_rem;
    logic [REM_W-1:0]      r_div, n_div;
    chm_pkg::t_cls         r_cls, n_cls;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;

    // Two-entry queue
    logic                  r_qv [2];
    chm_pkg::t_cls         r_qc [2];
    logic [KEY_BITS-1:0]   r_qk [2];
    logic [VALUE_BITS-1:0] r_qd [2];
    logic [BKT_W-1:0]      r_qb [2];
    logic                  r_wp, r_rp;

    logic                  w_push, w_pop, w_done;
    logic [REM_W:0]        w_trial;
    logic [REM_W-1:0]      w_div;

    assign o_in_ready = !r_busy;
    assign w_done     = r_busy && (r_cnt == '0) && !r_qv[r_wp];
    assign w_push     = w_done;
    assign w_pop      = o_q_valid && i_q_ready;
    assign w_trial    = {r_rem[REM_W-1:0], r_sh[SH_W-1]};

    // Saturate the divisor into 1..MAX_BUCKETS
    always_comb begin
        if (i_bucket_count == '0) begin
            w_div = REM_W'(1);
        end else if (32'(i_bucket_count) > MAX_BUCKETS) begin
            w_div = REM_W'(MAX_BUCKETS);
        end else begin
            w_div = i_bucket_count;
        end
    end

    // Accept and iterate
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cls  = r_cls;
        n_key  = r_key;
        n_val  = r_val;
        if (!r_busy && i_in_valid) begin
            n_busy         = 1'b1;
            n_sh           = i_key[KEY_BITS-1:2];
            n_rem          = '0;
            n_div          = w_div;
            n_cls.cmd      = i_cmd;
            n_cls.is_zero  = (i_key == '0);
            n_cls.is_bad   = (i_cmd != chm_pkg::CMD_ADD) && (i_cmd != chm_pkg::CMD_LOOKUP)
                             && (i_cmd != chm_pkg::CMD_REMOVE);
            n_key          = i_key;
            n_val          = i_value;
            n_cnt          = CNT_W'(SH_W);
        end else if (r_busy && r_cnt != '0) begin
            n_sh  = r_sh << 1;
            n_cnt = r_cnt - 1'b1;
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_trial - {1'b0, r_div};
            end else begin
                n_rem = w_trial;
            end
        end else if (w_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cls <= n_cls;
        r_key <= n_key;
        r_val <= n_val;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
            r_qv[1] <= 1'b0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            if (w_push) begin
                r_qv[r_wp] <= 1'b1;
                r_wp       <= !r_wp;
            end
            if (w_pop) begin
                r_qv[r_rp] <= 1'b0;
                r_rp       <= !r_rp;
            end
        end
        if (w_push) begin
            r_qc[r_wp] <= r_cls;
            r_qk[r_wp] <= r_key;
            r_qd[r_wp] <= r_val;
            r_qb[r_wp] <= r_rem[BKT_W-1:0];
        end
    end

    assign o_q_valid  = r_qv[r_rp];
    assign o_q_cls    = r_qc[r_rp];
    assign o_q_key    = r_qk[r_rp];
    assign o_q_value  = r_qd[r_rp];
    assign o_q_bucket = r_qb[r_rp];

`ifndef SYNTHESIS
    // The remainder is below the divisor once the iteration ends
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == '0 |-> r_rem < {1'b0, r_div})
        else $error("modulo remainder out of range");
    // No push into an occupied slot
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !r_qv[r_wp])
        else $error("queue overrun");
    // Ready only when the modulo unit is free
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_busy)
        else $error("ready while busy");
`endif

endmodule

@@ design/chm_back.sv @@
// Back part: walks the bucket chain in node memories and produces result beats.
module chm_back #(
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_NODES  = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    parameter int BKT_W       = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_ready,
    input  chm_pkg::t_cls         i_q_cls,
    input  logic [KEY_BITS-1:0]   i_q_key,
    input  logic [VALUE_BITS-1:0] i_q_value,
    input  logic [BKT_W-1:0]      i_q_bucket,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_found,
    output logic [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]            o_status
);

    localparam int NA_W = $clog2(POOL_NODES);   // node address
    localparam int LK_W = $clog2(POOL_NODES + 1); // link incl. null
    localparam logic [LK_W-1:0] NIL = LK_W'(POOL_NODES);
    localparam int ST_W  = LK_W + 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HCLR  = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;
    localparam logic [3:0] S_HWAIT = 4'd3;
    localparam logic [3:0] S_FLRD  = 4'd4;
    localparam logic [3:0] S_FLWT  = 4'd5;
    localparam logic [3:0] S_ADDW  = 4'd6;
    localparam logic [3:0] S_NRD   = 4'd7;
    localparam logic [3:0] S_NWT   = 4'd8;
    localparam logic [3:0] S_RMLK  = 4'd9;
    localparam logic [3:0] S_RMWT  = 4'd10;
    localparam logic [3:0] S_RMFIX = 4'd11;
    localparam logic [3:0] S_RMFR  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]            r_st, n_st;
    logic [BKT_W:0]        r_clr, n_clr;
    logic [LK_W-1:0]       r_free, n_free;
    logic [LK_W-1:0]       r_fresh, n_fresh;
    logic [LK_W-1:0]       r_cur, n_cur;
    logic [LK_W-1:0]       r_prev, n_prev;
    logic [LK_W-1:0]       r_node, n_node;
    logic [ST_W-1:0]       r_steps, n_steps;
    logic                  r_found, n_found;
    logic [VALUE_BITS-1:0] r_res, n_res;
    logic [1:0]            r_status, n_status;

    // Memory ports
    logic                  w_hwe, w_kwe, w_vwe, w_lwe;
    logic [BKT_W-1:0]      w_hadr;
    logic [LK_W-1:0]       w_hwd, w_hrd;
    logic [NA_W-1:0]       w_kadr, w_ladr;
    logic [KEY_BITS-1:0]   w_krd;
    logic [VALUE_BITS-1:0] w_vrd;
    logic [LK_W-1:0]       w_lwd, w_lrd, w_lrd_sat;

    chm_ram #(.WIDTH(LK_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(w_hwe), .i_addr(w_hadr), .i_wdata(w_hwd), .o_rdata(w_hrd));
    chm_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_keys (
        .i_clk(i_clk), .i_we(w_kwe), .i_addr(w_kadr), .i_wdata(i_q_key), .o_rdata(w_krd));
    chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_vals (
        .i_clk(i_clk), .i_we(w_vwe), .i_addr(w_kadr), .i_wdata(i_q_value), .o_rdata(w_vrd));
    chm_ram #(.WIDTH(LK_W), .DEPTH(POOL_NODES)) u_links (
        .i_clk(i_clk), .i_we(w_lwe), .i_addr(w_ladr), .i_wdata(w_lwd), .o_rdata(w_lrd));

    assign w_lrd_sat = (w_lrd > NIL) ? NIL : w_lrd;
    assign o_q_ready = (r_st == S_OUT) && i_ready;
    assign o_valid        = (r_st == S_OUT);
    assign o_found        = r_found;
    assign o_result_value = r_res;
    assign o_status       = r_status;

    // Sequencer
    always_comb begin
        n_st     = r_st;
        n_clr    = r_clr;
        n_free   = r_free;
        n_fresh  = r_fresh;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_node   = r_node;
        n_steps  = r_steps;
        n_found  = r_found;
        n_res    = r_res;
        n_status = r_status;
        w_hwe  = 1'b0;
        w_hadr = i_q_bucket;
        w_hwd  = r_node;
        w_kwe  = 1'b0;
        w_vwe  = 1'b0;
        w_kadr = r_cur[NA_W-1:0];
        w_lwe  = 1'b0;
        w_ladr = r_cur[NA_W-1:0];
        w_lwd  = w_hrd;
        case (r_st)
            S_HCLR: begin
                w_hwe  = 1'b1;
                w_hadr = r_clr[BKT_W-1:0];
                w_hwd  = NIL;
                n_clr  = r_clr + 1'b1;
                if (32'(r_clr) == MAX_BUCKETS - 1) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                n_found  = 1'b0;
                n_res    = '0;
                if (i_q_valid) begin
                    if (i_q_cls.is_zero) begin
                        n_status = chm_pkg::ST_ZERO;
                        n_st     = S_OUT;
                    end else if (i_q_cls.is_bad) begin
                        n_status = chm_pkg::ST_MISS;
                        n_st     = S_OUT;
                    end else begin
                        n_st = S_HRD;
                    end
                end
            end
            S_HRD: begin
                n_st = S_HWAIT;
            end
            S_HWAIT: begin
                n_cur   = w_hrd;
                n_prev  = NIL;
                n_steps = '0;
                if (i_q_cls.cmd == chm_pkg::CMD_ADD) begin
                    if (r_free < NIL) begin
                        n_node = r_free;
                        n_st   = S_FLRD;
                    end else if (r_fresh < NIL) begin
                        n_node  = r_fresh;
                        n_fresh = r_fresh + 1'b1;
                        n_st    = S_ADDW;
                    end else begin
                        n_status = chm_pkg::ST_FULL;
                        n_st     = S_OUT;
                    end
                end else begin
                    n_st = S_NRD;
                end
            end
            S_FLRD: begin
                w_ladr = r_node[NA_W-1:0];
                n_st   = S_FLWT;
            end
            S_FLWT: begin
                n_free = w_lrd_sat;
                n_st   = S_ADDW;
            end
            S_ADDW: begin
                // new node links to the old head, becomes the head
                w_kadr = r_node[NA_W-1:0];
                w_ladr = r_node[NA_W-1:0];
                w_kwe  = 1'b1;
                w_vwe  = 1'b1;
                w_lwe  = 1'b1;
                w_lwd  = r_cur;
                w_hwe  = 1'b1;
                w_hwd  = r_node;
                n_status = chm_pkg::ST_OK;
                n_st     = S_OUT;
            end
            S_NRD: begin
                if (r_cur >= NIL || 32'(r_steps) >= POOL_NODES) begin
                    n_status = chm_pkg::ST_MISS;
                    n_st     = S_OUT;
                end else begin
                    n_st = S_NWT;
                end
            end
            S_NWT: begin
                if (w_krd == i_q_key) begin
                    n_found  = 1'b1;
                    n_res    = w_vrd;
                    n_status = chm_pkg::ST_OK;
                    n_node   = w_lrd_sat;
                    n_st     = (i_q_cls.cmd == chm_pkg::CMD_REMOVE) ? S_RMFIX : S_OUT;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = w_lrd;
                    n_steps = r_steps + 1'b1;
                    n_st    = S_NRD;
                end
            end
            S_RMFIX: begin
                // predecessor or head skips the matched node
                if (r_prev >= NIL) begin
                    w_hwe = 1'b1;
                    w_hwd = r_node;
                end else begin
                    w_ladr = r_prev[NA_W-1:0];
                    w_lwe  = 1'b1;
                    w_lwd  = r_node;
                end
                n_st = S_RMFR;
            end
            S_RMFR: begin
                w_lwe  = 1'b1;
                w_lwd  = r_free;
                n_free = r_cur;
                n_st   = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_HCLR;
            r_clr   <= '0;
            r_free  <= NIL;
            r_fresh <= '0;
        end else begin
            r_st    <= n_st;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_fresh <= n_fresh;
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_node   <= n_node;
        r_steps  <= n_steps;
        r_found  <= n_found;
        r_res    <= n_res;
        r_status <= n_status;
    end

`ifndef SYNTHESIS
    // Fresh allocation never passes the pool size
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL)
        else $error("fresh count past pool");
    // A found result always carries ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == chm_pkg::ST_OK)
        else $error("found with bad status");
    // Memory writes never happen during the result hold
    a_no_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |-> !w_hwe && !w_lwe && !w_kwe)
        else $error("write while presenting result");
`endif

endmodule

@@ design/chained_hash_map.sv @@
// Top level of the chained hash map.
//   channel | dir | beat fields (low bit first)
//   s_axis  | in  | tdata: command[1:0], key[33:2], value[65:34]
//   m_axis  | out | tdata: found[0], result_value[32:1], status[34:33]
//   cfg     | in  | bucket_count on i_cfg_wdata, write when i_cfg_we
// After reset the back clears all MAX_BUCKETS bucket heads; input beats
// still enter the front and the queue, but no result beat comes out until the clear ends.
// The front holds s_axis_tready low after each beat through KEY_BITS-2 modulo steps
// (one key bit a cycle) and until it pushes into the queue, which needs a free entry.
// An add reads the bucket head, takes a node from the free list or fresh pool, writes it;
// look up and remove walk the chain from the head; remove then unlinks and frees the node.
// A two-entry queue between them lets the front start the next modulo early.
// Reset is synchronous, active low; output beats hold while m_axis_tready is low.
module chained_hash_map #(
    parameter int MAX_BUCKETS = 256,
    parameter int POOL_NODES  = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // command, key, value (low to high), zero padded
    input  logic [((2+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // found, result_value, status (low to high), zero padded
    output logic [((3+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [chm_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int OW    = ((3 + VALUE_BITS + 7) / 8) * 8;

    logic [chm_pkg::CFG_BITS-1:0] r_bcount;
    logic                  w_qv, w_qr, w_found;
    chm_pkg::t_cls         w_qc;
    logic [KEY_BITS-1:0]   w_qk;
    logic [VALUE_BITS-1:0] w_qd, w_res;
    logic [BKT_W-1:0]      w_qb;
    logic [1:0]            w_status;

    // Bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= chm_pkg::CFG_BITS'(MAX_BUCKETS);
        end else if (i_cfg_we) begin
            r_bcount <= i_cfg_wdata;
        end
    end

    chm_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
                .BKT_W(BKT_W), .REM_W(chm_pkg::CFG_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[1:0]), .i_key(s_axis_tdata[KEY_BITS+1:2]),
        .i_value(s_axis_tdata[KEY_BITS+VALUE_BITS+1:KEY_BITS+2]),
        .i_bucket_count(r_bcount),
        .o_q_valid(w_qv), .i_q_ready(w_qr), .o_q_cls(w_qc), .o_q_key(w_qk),
        .o_q_value(w_qd), .o_q_bucket(w_qb));

    chm_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES), .KEY_BITS(KEY_BITS),
               .VALUE_BITS(VALUE_BITS), .BKT_W(BKT_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .o_q_ready(w_qr), .i_q_cls(w_qc), .i_q_key(w_qk),
        .i_q_value(w_qd), .i_q_bucket(w_qb),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_found(w_found), .o_result_value(w_res), .o_status(w_status));

    assign m_axis_tdata = OW'({w_status, w_res, w_found});

endmodule

@@ verif/tb.sv @@
// Testbench for the chained hash map: directed and random command streams against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BUCKETS = 256;
    localparam int POOL_NODES  = 1024;
    localparam int NIL         = POOL_NODES;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 40;
    localparam int CYCLE_LIMIT = 2000000;

    // Packed to match the output beat: status high, found low
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic        found;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // command[1:0], key[33:2], value[65:34]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // found[0], result_value[32:1], status[34:33]
    logic              i_cfg_we;
    logic [chm_pkg::CFG_BITS-1:0] i_cfg_wdata;

    chained_hash_map dut (.*);

    // Predictor state
    int          heads[MAX_BUCKETS];
    logic [31:0] nkeys[POOL_NODES];
    logic [31:0] nvals[POOL_NODES];
    int          nlinks[POOL_NODES];
    int          free_head;
    int          fresh_count;
    int          buckets;

    t_answer     pending_answers[$];
    int          err_count;
    int          answers_seen;
    int          cycle_count;
    bit          hold_off_req;
    logic [31:0] used_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic void table_reset();
        for (int i = 0; i < MAX_BUCKETS; i++) heads[i] = NIL;
        free_head = NIL;
        fresh_count = 0;
        buckets = MAX_BUCKETS;
    endfunction

    function automatic void set_buckets(int v);
        if (v == 0) v = 1;
        if (v > MAX_BUCKETS) v = MAX_BUCKETS;
        buckets = v;
    endfunction

    // Expected answer for one command, updating the table
    function automatic t_answer hash_map_apply(logic [1:0] cmd, logic [31:0] key,
                                                logic [31:0] val);
        t_answer a;
        int b;
        int cur;
        int prev;
        int n;
        int steps;
        a = '{found: 1'b0, value: 32'd0, status: chm_pkg::ST_MISS};
        if (key == 0) begin
            a.status = chm_pkg::ST_ZERO;
            return a;
        end
        if (cmd != chm_pkg::CMD_ADD && cmd != chm_pkg::CMD_LOOKUP
            && cmd != chm_pkg::CMD_REMOVE) return a;
        b = int'((key >> 2) % buckets);
        if (cmd == chm_pkg::CMD_ADD) begin
            if (free_head < NIL) begin
                n = free_head;
                free_head = nlinks[n];
            end else if (fresh_count < POOL_NODES) begin
                n = fresh_count;
                fresh_count++;
            end else begin
                a.status = chm_pkg::ST_FULL;
                return a;
            end
            nkeys[n] = key;
            nvals[n] = val;
            nlinks[n] = heads[b];
            heads[b] = n;
            a.status = chm_pkg::ST_OK;
            return a;
        end
        prev = NIL;
        cur = heads[b];
        steps = 0;
        while (cur < NIL && steps < POOL_NODES && nkeys[cur] != key) begin
            prev = cur;
            cur = nlinks[cur];
            steps++;
        end
        if (cur >= NIL || steps >= POOL_NODES) return a;
        if (cmd == chm_pkg::CMD_REMOVE) begin
            if (prev >= NIL) heads[b] = nlinks[cur];
            else nlinks[prev] = nlinks[cur];
            nlinks[cur] = free_head;
            free_head = cur;
        end
        a.found = 1'b1;
        a.value = nvals[cur];
        a.status = chm_pkg::ST_OK;
        return a;
    endfunction

    // Send one command beat, bursts with random gaps
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] key, logic [31:0] val);
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, val, key, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_answers.push_back(hash_map_apply(cmd, key, val));
        if (cmd == chm_pkg::CMD_ADD && key != 0) used_keys.push_back(key);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        // front modulo plus a long chain walk
        repeat (3000) @(negedge i_clk);
    endtask

    task automatic write_buckets(int v);
        go_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= chm_pkg::CFG_BITS'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_buckets(v);
    endtask

    // Receiver: stall pattern plus a requested long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (hold_off_req) m_axis_tready <= 1'b0;
        else m_axis_tready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Answer checker
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_answer'(m_axis_tdata[34:0]);
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("unexpected answer beat %h", m_axis_tdata);
                err_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, got.found);
                    err_count++;
                end
                if (got.value !== want.value) begin
                    $error("result_value: expected %h actual %h", want.value, got.value);
                    err_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom_range(0, 3) == 0 ? ($urandom & 32'h3fc) | 32'h4 : $urandom | 32'h1;
    endfunction

    task automatic test_directed();
        send_cmd(chm_pkg::CMD_LOOKUP, 32'hffff_ffff, 0);
        send_cmd(chm_pkg::CMD_ADD, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(chm_pkg::CMD_ADD, 32'h0000_0004, 32'h0);
        send_cmd(chm_pkg::CMD_ADD, 32'h0000_0004, 32'h1234_5678);
        send_cmd(chm_pkg::CMD_LOOKUP, 32'h0000_0004, 0);
        send_cmd(chm_pkg::CMD_REMOVE, 32'h0000_0004, 0);
        send_cmd(chm_pkg::CMD_LOOKUP, 32'h0000_0004, 0);
        send_cmd(chm_pkg::CMD_LOOKUP, 32'hffff_ffff, 0);
        send_cmd(chm_pkg::CMD_ADD, 32'h0, 32'h5);
        send_cmd(chm_pkg::CMD_LOOKUP, 32'h0, 0);
        send_cmd(chm_pkg::CMD_REMOVE, 32'h0, 0);
        send_cmd(2'd3, 32'h0000_0404, 32'hffff_ffff);
        send_cmd(chm_pkg::CMD_REMOVE, 32'h0000_0404, 0);
        send_cmd(chm_pkg::CMD_REMOVE, 32'h0000_0004, 0);
        send_cmd(chm_pkg::CMD_REMOVE, 32'h0000_0004, 0);
        send_cmd(chm_pkg::CMD_ADD, 32'h8000_0000, 32'haaaa_5555);
        send_cmd(chm_pkg::CMD_LOOKUP, 32'h8000_0000, 0);
    endtask

    task automatic test_random(int count);
        logic [1:0] cmd;
        for (int i = 0; i < count; i++) begin
            cmd = chm_pkg::CMD_ADD;
            case ($urandom_range(0, 19))
                0:  cmd = 2'd3;
                1, 2, 3, 4, 5, 6, 7: cmd = chm_pkg::CMD_ADD;
                8, 9, 10, 11, 12, 13: cmd = chm_pkg::CMD_LOOKUP;
                default: cmd = chm_pkg::CMD_REMOVE;
            endcase
            send_cmd(cmd, $urandom_range(0, 40) == 0 ? 32'd0 : pick_key(), $urandom);
        end
    endtask

    // Receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            test_random(12);
        join
    endtask

    // Exhaust the node pool, then free and reuse nodes
    task automatic test_pool_full();
        for (int i = 0; i < POOL_NODES + 3; i++)
            send_cmd(chm_pkg::CMD_ADD, 32'h1000_0000 + (i << 2), i);
        for (int i = 0; i < 6; i++)
            send_cmd(chm_pkg::CMD_REMOVE, 32'h1000_0000 + (i << 4), 0);
        test_random(30);
    endtask

    initial begin
        err_count = 0;
        answers_seen = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        table_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        write_buckets(1);
        test_random(150);
        write_buckets(0);
        test_backpressure();
        write_buckets(511);
        test_random(150);
        write_buckets(7);
        test_random(150);
        write_buckets(256);
        test_random(150);
        test_pool_full();
        go_idle();
        $display("Covered directed cases, bucket counts 1/0/511/7/256, back-pressure and pool full.");
        $display("Answers checked: %0d, errors: %0d", answers_seen, err_count);
        if (err_count == 0 && pending_answers.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/chm_pkg.sv
design/chm_ram.sv
design/chm_front.sv
design/chm_back.sv
design/chained_hash_map.sv
verif/tb.sv
